### design/assert_macros.svh
// Assertion macros for the monitor design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SJDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SJDM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SJDM_ASSERT(label, clk, rst, prop, msg)
`define SJDM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### design/sjdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sjdm_pkg;

   localparam int HISTORY_DEPTH_DEF = 600;
   localparam int SLOT_COUNT_DEF    = 8;

   localparam logic [9:0]  WINDOW_RESET   = 10'd120;
   localparam logic [14:0] DEADZONE_RESET = 15'd4915;
   localparam logic [15:0] NOISY_RESET    = 16'd655;
   localparam logic [15:0] STILL_RESET    = 16'd164;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] REG_WINDOW   = 2'd0;
   localparam logic [1:0] REG_DEADZONE = 2'd1;
   localparam logic [1:0] REG_NOISY    = 2'd2;
   localparam logic [1:0] REG_STILL    = 2'd3;

   localparam logic [1:0] VERDICT_CLEAN = 2'd0;
   localparam logic [1:0] VERDICT_NOISY = 2'd1;
   localparam logic [1:0] VERDICT_DRIFT = 2'd2;

   localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

   // Window sum, squared deviation and accumulator widths for up to 1023 samples.
   localparam int SUM_W      = 26;
   localparam int SQ_W       = 34;
   localparam int DIV_W      = 42;
   localparam int REM_W      = 10;
   localparam int ROOT_W     = 33;
   localparam int ROOT_STEPS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_SQ,
      ST_VAR,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### design/stick_jitter_drift_monitor.sv
// One push runs, for each axis in turn over a window of n samples, two read passes
// over the history memory, one shared 42-step restoring divider used twice per axis
// and a 16-step square root (only the first pass when n is under two); a clear or an
// out-of-range slot goes straight to the response. One request is in flight at a time.
// Reset (synchronous, active high) restores the register defaults and empties
// every stick; the history memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stick_jitter_drift_monitor #(
   parameter int HISTORY_DEPTH = sjdm_pkg::HISTORY_DEPTH_DEF,
   parameter int SLOT_COUNT    = sjdm_pkg::SLOT_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [2:0]         req_slot,
   input  wire logic               req_stick,
   input  wire logic signed [15:0] req_sample_x,
   input  wire logic signed [15:0] req_sample_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_jitter_x,
   output logic [15:0]             rsp_jitter_y,
   output logic [15:0]             rsp_peak_x,
   output logic [15:0]             rsp_peak_y,
   output logic [1:0]              rsp_verdict_x,
   output logic [1:0]              rsp_verdict_y,
   output logic [15:0]             rsp_unchanged_frames,
   output logic [9:0]              rsp_held_samples,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int STICKS    = SLOT_COUNT * 2;
   localparam int IDX_W     = $clog2(STICKS);
   localparam int PTR_W     = $clog2(HISTORY_DEPTH);
   localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W     = (FILL_W > 10) ? FILL_W : 10;
   localparam int SP_W      = $clog2(2 * HISTORY_DEPTH + 1);
   localparam int MEM_DEPTH = STICKS * HISTORY_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int SUM_W     = sjdm_pkg::SUM_W;
   localparam int SQ_W      = sjdm_pkg::SQ_W;
   localparam int DIV_W     = sjdm_pkg::DIV_W;
   localparam int REM_W     = sjdm_pkg::REM_W;
   localparam int ROOT_W    = sjdm_pkg::ROOT_W;

   // configuration registers
   logic [9:0]  window_ff;
   logic [14:0] deadzone_ff;
   logic [15:0] noisy_ff;
   logic [15:0] still_lim_ff;

   // per-stick state
   logic [PTR_W-1:0]  wpos_ff  [STICKS];
   logic [FILL_W-1:0] fill_ff  [STICKS];
   logic [15:0]       prevx_ff [STICKS];
   logic [15:0]       prevy_ff [STICKS];
   logic [15:0]       still_ff [STICKS];

   // history memories
   logic [15:0] hist_x [MEM_DEPTH];
   logic [15:0] hist_y [MEM_DEPTH];
   logic signed [15:0] rdx_ff;
   logic signed [15:0] rdy_ff;

   // sequencer
   sjdm_pkg::state_type state_ff, state_in;
   logic                axis_ff;
   logic [9:0]          n_ff;
   logic [PTR_W-1:0]    start_ff;
   logic [PTR_W-1:0]    ptr_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [9:0]          cnt_ff;
   logic                rdv_ff;
   logic                sqv_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [15:0]         peak_ff;
   logic signed [16:0]  mean_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic [DIV_W-1:0]    acc_ff;
   logic [DIV_W-1:0]    dq_ff;
   logic [REM_W-1:0]    drem_ff;
   logic [5:0]          step_ff;
   logic [ROOT_W-1:0]   sv_ff;
   logic [ROOT_W-1:0]   sres_ff;
   logic [ROOT_W-1:0]   sbit_ff;

   // per-axis results and stick status of the current request
   logic [15:0] jit_x_ff, jit_y_ff, pk_x_ff, pk_y_ff;
   logic [1:0]  ver_x_ff, ver_y_ff;
   logic [15:0] unch_ff;
   logic [9:0]  held_ff;

   // response register
   logic        rsp_valid_ff;
   logic [15:0] rsp_jit_x_ff, rsp_jit_y_ff, rsp_pk_x_ff, rsp_pk_y_ff;
   logic [1:0]  rsp_ver_x_ff, rsp_ver_y_ff;
   logic [15:0] rsp_unch_ff;
   logic [9:0]  rsp_held_ff;

   // request decode
   logic              req_fire;
   logic              slot_ok;
   logic              is_push;
   logic [IDX_W-1:0]  idx_in;
   logic [IDX_W-1:0]  idx0_in;
   logic [IDX_W-1:0]  idx1_in;
   logic [PTR_W-1:0]  wp_cur;
   logic [PTR_W-1:0]  wp_in;
   logic [FILL_W-1:0] fill_cur;
   logic [FILL_W-1:0] fill_in;
   logic [15:0]       still_in;
   logic              changed;
   logic [9:0]        n_in;
   logic [SP_W-1:0]   sp_tmp;
   logic [PTR_W-1:0]  start_in;
   logic [ADDR_W-1:0] base_in;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;

   // control
   logic issue;
   logic pass_end_sum;
   logic pass_end_sq;
   logic div_last;
   logic root_last;
   logic axis_end;
   logic out_free;

   // datapath helpers
   logic signed [15:0]       sample;
   logic [15:0]              sample_abs;
   logic [SUM_W-1:0]         sum_abs;
   logic [REM_W:0]           rsh;
   logic                     dge;
   logic [REM_W:0]           rnew;
   logic [DIV_W-1:0]         dq_in;
   logic signed [16:0]       mean_in;
   logic signed [17:0]       dev;
   logic [16:0]              dev_abs;
   logic [ROOT_W-1:0]        strial;
   logic                     sge;
   logic [ROOT_W-1:0]        sres_in;
   logic [15:0]              jt_cur;
   logic [1:0]               verdict_in;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == sjdm_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Decode the request and work out the stick's next status.
   always_comb begin
      slot_ok  = ({2'b00, req_slot} < 5'(SLOT_COUNT));
      is_push  = slot_ok && (req_command == sjdm_pkg::CMD_PUSH);
      idx_in   = IDX_W'({1'b0, req_slot, req_stick});
      idx0_in  = IDX_W'({1'b0, req_slot, 1'b0});
      idx1_in  = IDX_W'({1'b0, req_slot, 1'b1});
      wp_cur   = wpos_ff[idx_in];
      wp_in    = (wp_cur == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_cur + PTR_W'(1);
      fill_cur = fill_ff[idx_in];
      fill_in  = (fill_cur == FILL_W'(HISTORY_DEPTH)) ? fill_cur : fill_cur + FILL_W'(1);
      changed  = (req_sample_x != prevx_ff[idx_in]) || (req_sample_y != prevy_ff[idx_in]);
      if (changed) begin
         still_in = '0;
      end else if (still_ff[idx_in] == sjdm_pkg::COUNTER_MAX) begin
         still_in = still_ff[idx_in];
      end else begin
         still_in = still_ff[idx_in] + 16'd1;
      end
      n_in     = (CMP_W'(window_ff) < CMP_W'(fill_in)) ? window_ff : 10'(fill_in);
      sp_tmp   = SP_W'(wp_in) + SP_W'(HISTORY_DEPTH) - SP_W'(n_in);
      start_in = (sp_tmp >= SP_W'(HISTORY_DEPTH)) ?
                 PTR_W'(sp_tmp - SP_W'(HISTORY_DEPTH)) : PTR_W'(sp_tmp);
      base_in  = ADDR_W'(idx_in) * ADDR_W'(HISTORY_DEPTH);
      waddr    = base_in + ADDR_W'(wp_cur);
      raddr    = base_ff + ADDR_W'(ptr_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sjdm_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = is_push ? sjdm_pkg::ST_SUM : sjdm_pkg::ST_DONE;
            end
         end
         sjdm_pkg::ST_SUM: begin
            if (pass_end_sum) begin
               if (n_ff >= 10'd2) begin
                  state_in = sjdm_pkg::ST_MEAN;
               end else if (axis_ff) begin
                  state_in = sjdm_pkg::ST_DONE;
               end
            end
         end
         sjdm_pkg::ST_MEAN: begin
            if (div_last) state_in = sjdm_pkg::ST_SQ;
         end
         sjdm_pkg::ST_SQ: begin
            if (pass_end_sq) state_in = sjdm_pkg::ST_VAR;
         end
         sjdm_pkg::ST_VAR: begin
            if (div_last) state_in = sjdm_pkg::ST_ROOT;
         end
         sjdm_pkg::ST_ROOT: begin
            if (root_last) state_in = axis_ff ? sjdm_pkg::ST_DONE : sjdm_pkg::ST_SUM;
         end
         sjdm_pkg::ST_DONE: begin
            if (out_free) state_in = sjdm_pkg::ST_IDLE;
         end
         default: state_in = sjdm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer strobes.
   always_comb begin
      issue        = 1'b0;
      pass_end_sum = 1'b0;
      pass_end_sq  = 1'b0;
      div_last     = 1'b0;
      root_last    = 1'b0;
      case (state_ff)
         sjdm_pkg::ST_SUM: begin
            issue        = (cnt_ff < n_ff);
            pass_end_sum = (cnt_ff == n_ff) && !rdv_ff;
         end
         sjdm_pkg::ST_SQ: begin
            issue       = (cnt_ff < n_ff);
            pass_end_sq = (cnt_ff == n_ff) && !rdv_ff && !sqv_ff;
         end
         sjdm_pkg::ST_MEAN, sjdm_pkg::ST_VAR: begin
            div_last = (step_ff == 6'(DIV_W - 1));
         end
         sjdm_pkg::ST_ROOT: begin
            root_last = (step_ff == 6'(sjdm_pkg::ROOT_STEPS - 1));
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      axis_end = (pass_end_sum && (n_ff < 10'd2)) || root_last;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // Shared arithmetic: one divider step, one root step, deviation and verdict.
   always_comb begin
      sample     = axis_ff ? rdy_ff : rdx_ff;
      sample_abs = sample[15] ? 16'(-17'(sample)) : 16'(sample);
      sum_abs    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      rsh        = {drem_ff, dq_ff[DIV_W-1]};
      dge        = (rsh >= (REM_W+1)'(n_ff));
      rnew       = dge ? rsh - (REM_W+1)'(n_ff) : rsh;
      dq_in      = {dq_ff[DIV_W-2:0], dge};
      mean_in    = sum_ff[SUM_W-1] ? -17'(dq_in[16:0]) : 17'(dq_in[16:0]);
      dev        = 18'(sample) - 18'(mean_ff);
      dev_abs    = dev[17] ? 17'(-dev) : 17'(dev);
      strial     = sres_ff + sbit_ff;
      sge        = (sv_ff >= strial);
      sres_in    = sge ? (sres_ff >> 1) + sbit_ff : (sres_ff >> 1);
      jt_cur     = root_last ? sres_in[15:0] : 16'd0;
      if (jt_cur > noisy_ff) begin
         verdict_in = sjdm_pkg::VERDICT_NOISY;
      end else if ((18'(peak_ff) * 18'd5 > 18'(deadzone_ff) * 18'd3) &&
                   (jt_cur < still_lim_ff)) begin
         verdict_in = sjdm_pkg::VERDICT_DRIFT;
      end else begin
         verdict_in = sjdm_pkg::VERDICT_CLEAN;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= sjdm_pkg::WINDOW_RESET;
         deadzone_ff  <= sjdm_pkg::DEADZONE_RESET;
         noisy_ff     <= sjdm_pkg::NOISY_RESET;
         still_lim_ff <= sjdm_pkg::STILL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sjdm_pkg::REG_WINDOW:   window_ff    <= csr_data[9:0];
            sjdm_pkg::REG_DEADZONE: deadzone_ff  <= csr_data[14:0];
            sjdm_pkg::REG_NOISY:    noisy_ff     <= csr_data;
            sjdm_pkg::REG_STILL:    still_lim_ff <= csr_data;
            default:                window_ff    <= window_ff;
         endcase
      end
   end

   // Per-stick status: advance on a push, zero both sticks on a clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < STICKS; j++) begin
            wpos_ff[j]  <= '0;
            fill_ff[j]  <= '0;
            prevx_ff[j] <= '0;
            prevy_ff[j] <= '0;
            still_ff[j] <= '0;
         end
      end else if (req_fire && slot_ok) begin
         if (req_command == sjdm_pkg::CMD_CLEAR) begin
            wpos_ff[idx0_in]  <= '0;
            fill_ff[idx0_in]  <= '0;
            prevx_ff[idx0_in] <= '0;
            prevy_ff[idx0_in] <= '0;
            still_ff[idx0_in] <= '0;
            wpos_ff[idx1_in]  <= '0;
            fill_ff[idx1_in]  <= '0;
            prevx_ff[idx1_in] <= '0;
            prevy_ff[idx1_in] <= '0;
            still_ff[idx1_in] <= '0;
         end else begin
            wpos_ff[idx_in]  <= wp_in;
            fill_ff[idx_in]  <= fill_in;
            prevx_ff[idx_in] <= req_sample_x;
            prevy_ff[idx_in] <= req_sample_y;
            still_ff[idx_in] <= still_in;
         end
      end
   end

   // History memories: the push writes in its accept cycle, passes read later.
   always_ff @(posedge clock) begin
      if (req_fire && is_push) begin
         hist_x[waddr] <= req_sample_x;
         hist_y[waddr] <= req_sample_y;
      end
      rdx_ff <= hist_x[raddr];
      rdy_ff <= hist_y[raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sjdm_pkg::ST_IDLE;
         axis_ff      <= 1'b0;
         rdv_ff       <= 1'b0;
         sqv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= issue;
         sqv_ff   <= (state_ff == sjdm_pkg::ST_SQ) && rdv_ff;
         if (req_fire) begin
            axis_ff <= 1'b0;
         end else if (axis_end && !axis_ff) begin
            axis_ff <= 1'b1;
         end
         if (state_ff == sjdm_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (issue) begin
         ptr_ff <= (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
         cnt_ff <= cnt_ff + 10'd1;
      end
      if (req_fire) begin
         n_ff     <= is_push ? n_in : 10'd0;
         start_ff <= start_in;
         ptr_ff   <= start_in;
         base_ff  <= base_in;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         peak_ff  <= '0;
         jit_x_ff <= '0;
         jit_y_ff <= '0;
         pk_x_ff  <= '0;
         pk_y_ff  <= '0;
         ver_x_ff <= sjdm_pkg::VERDICT_CLEAN;
         ver_y_ff <= sjdm_pkg::VERDICT_CLEAN;
         unch_ff  <= is_push ? still_in : 16'd0;
         held_ff  <= is_push ? 10'(fill_in) : 10'd0;
      end
      // first pass: window sum and peak
      if (state_ff == sjdm_pkg::ST_SUM && rdv_ff) begin
         sum_ff <= sum_ff + SUM_W'(sample);
         if (sample_abs > peak_ff) peak_ff <= sample_abs;
      end
      if (pass_end_sum && n_ff >= 10'd2) begin
         dq_ff   <= DIV_W'(sum_abs);
         drem_ff <= '0;
         step_ff <= '0;
      end
      // shared divider, one quotient bit per cycle
      if (state_ff == sjdm_pkg::ST_MEAN || state_ff == sjdm_pkg::ST_VAR) begin
         dq_ff   <= dq_in;
         drem_ff <= rnew[REM_W-1:0];
         step_ff <= step_ff + 6'd1;
      end
      if (state_ff == sjdm_pkg::ST_MEAN && div_last) begin
         mean_ff <= mean_in;
         ptr_ff  <= start_ff;
         cnt_ff  <= '0;
         acc_ff  <= '0;
      end
      // second pass: squared deviations from the mean
      if (state_ff == sjdm_pkg::ST_SQ && rdv_ff) begin
         sq_ff <= SQ_W'(dev_abs) * SQ_W'(dev_abs);
      end
      if (sqv_ff) begin
         acc_ff <= acc_ff + DIV_W'(sq_ff);
      end
      if (pass_end_sq) begin
         dq_ff   <= acc_ff;
         drem_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == sjdm_pkg::ST_VAR && div_last) begin
         sv_ff   <= ROOT_W'(dq_in[32:0]);
         sres_ff <= '0;
         sbit_ff <= ROOT_W'(1) << 30;
         step_ff <= '0;
      end
      // floor square root, two radicand bits per cycle
      if (state_ff == sjdm_pkg::ST_ROOT) begin
         if (sge) sv_ff <= sv_ff - strial;
         sres_ff <= sres_in;
         sbit_ff <= sbit_ff >> 2;
         step_ff <= step_ff + 6'd1;
      end
      // hold the axis result, then rewind for the y axis
      if (axis_end) begin
         if (axis_ff) begin
            jit_y_ff <= jt_cur;
            pk_y_ff  <= peak_ff;
            ver_y_ff <= verdict_in;
         end else begin
            jit_x_ff <= jt_cur;
            pk_x_ff  <= peak_ff;
            ver_x_ff <= verdict_in;
            ptr_ff   <= start_ff;
            cnt_ff   <= '0;
            sum_ff   <= '0;
            peak_ff  <= '0;
         end
      end
      // response register
      if (state_ff == sjdm_pkg::ST_DONE && out_free) begin
         rsp_jit_x_ff <= jit_x_ff;
         rsp_jit_y_ff <= jit_y_ff;
         rsp_pk_x_ff  <= pk_x_ff;
         rsp_pk_y_ff  <= pk_y_ff;
         rsp_ver_x_ff <= ver_x_ff;
         rsp_ver_y_ff <= ver_y_ff;
         rsp_unch_ff  <= unch_ff;
         rsp_held_ff  <= held_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_jitter_x         = rsp_jit_x_ff;
   assign rsp_jitter_y         = rsp_jit_y_ff;
   assign rsp_peak_x           = rsp_pk_x_ff;
   assign rsp_peak_y           = rsp_pk_y_ff;
   assign rsp_verdict_x        = rsp_ver_x_ff;
   assign rsp_verdict_y        = rsp_ver_y_ff;
   assign rsp_unchanged_frames = rsp_unch_ff;
   assign rsp_held_samples     = rsp_held_ff;

   // The divider never runs on a window too short for a mean.
   `SJDM_ASSERT(a_div_window, clock, reset, (state_ff == sjdm_pkg::ST_MEAN) |-> (n_ff >= 10'd2), "divider started on short window")
   // A read pass never issues past the window.
   `SJDM_ASSERT(a_pass_bound, clock, reset, (state_ff == sjdm_pkg::ST_SUM || state_ff == sjdm_pkg::ST_SQ) |-> (cnt_ff <= n_ff), "read pass overran window")
   // The root unit starts from a cleared result.
   `SJDM_ASSERT(a_root_start, clock, reset, $rose(state_ff == sjdm_pkg::ST_ROOT) |-> (sres_ff == '0), "root started dirty")
   // Reset drops any pending response.
   `SJDM_ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule
`default_nettype wire
